// ===== rtl/mrc_pkg.sv =====
package mrc_pkg;

   localparam int MaxRegisters = 8;
   localparam int StoreBytes   = 2 * MaxRegisters;
   localparam int RowBits      = $clog2(MaxRegisters);
   localparam int ByteBits     = $clog2(StoreBytes);
   localparam int CsrAddrBits  = 3;

   localparam logic [15:0] CrcInit = 16'hFFFF;
   localparam logic [15:0] CrcPoly = 16'hA001;

   localparam logic [7:0] FuncRead     = 8'h03;
   localparam logic [7:0] FuncWrite    = 8'h06;
   localparam logic [7:0] FuncReadExc  = 8'h83;
   localparam logic [7:0] FuncWriteExc = 8'h86;

   localparam logic [CsrAddrBits-1:0] CsrExpectedAddress = 3'd0;

   typedef enum logic [2:0] {
      STAT_READ_OK   = 3'd0,
      STAT_WRITE_OK  = 3'd1,
      STAT_READ_EXC  = 3'd2,
      STAT_WRITE_EXC = 3'd3,
      STAT_ADDR_ERR  = 3'd4,
      STAT_CRC_ERR   = 3'd5,
      STAT_UNKNOWN   = 3'd6
   } status_type;

   typedef enum logic [2:0] {
      SEQ_IDLE,
      SEQ_CRC,
      SEQ_JUDGE,
      SEQ_FETCH,
      SEQ_SEND
   } seq_state_type;

   typedef struct packed {
      logic       init;
      logic       start;
      logic [7:0] data;
   } crc_ctrl_type;

   typedef struct packed {
      logic                wr_en;
      logic                clear;
      logic [ByteBits-1:0] wr_addr;
      logic [7:0]          wr_data;
      logic [RowBits-1:0]  rd_row;
   } store_ctrl_type;

endpackage

// ===== rtl/modbus_reply_checker.sv =====
// Modbus RTU reply checker.
// req_ channel: one reply byte per transaction, req_tlast on the final byte.
// rsp_ channel: results of a frame, emitted only after its final byte;
//   rsp_tuser marks a register read back, rsp_tlast the final result.
// csr_ port: register 0 at address 0 holds the expected slave address.
// Input flow: the first two bytes of a frame are taken back to back; every later
//   byte starts the bit-serial CRC unit, which shifts one bit per cycle, so
//   req_tready is low while it runs.
// Results: after the final byte (and its CRC pass, if any), the sequencer judges the
//   frame, then per result reads the register store and then loads the output register.
// Reset clears the sequencer, the CRC and the byte position, and sets the
//   expected address to 1. A stalled receiver holds the result in the output
//   register and stops the sequencer; the next frame's bytes are still taken
//   once the last result of a frame has been loaded.
module modbus_reply_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [7:0]                          req_tdata,   // [7:0] rx_byte
   input  logic                                req_tlast,   // end_of_frame
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [23:0]                         rsp_tdata,   // [2:0] status, [5:3] reg_index,
                                                            // [21:6] reg_value, [23:22] zero
   output logic                                rsp_tuser,   // reg_valid
   output logic                                rsp_tlast,   // last
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [mrc_pkg::CsrAddrBits-1:0]     csr_paddr,
   input  logic [31:0]                         csr_pwdata,
   output logic [31:0]                         csr_prdata,
   output logic                                csr_pready
);
   import mrc_pkg::*;

   seq_state_type       state_ff, state_in;
   logic [7:0]          pos_ff, pos_in;
   logic [7:0]          delay0_ff, delay0_in, delay1_ff, delay1_in;
   logic [7:0]          addr_byte_ff, addr_byte_in;
   logic [7:0]          func_ff, func_in;
   logic [7:0]          count_byte_ff, count_byte_in;
   logic [7:0]          frame_len_ff, frame_len_in;
   logic                eof_ff, eof_in;
   status_type          status_ff, status_in;
   logic [RowBits:0]    nreg_ff, nreg_in;
   logic [RowBits-1:0]  idx_ff, idx_in;
   logic [7:0]          exp_addr_ff;

   logic                rsp_valid_ff, rsp_valid_in;
   status_type          rsp_status_ff, rsp_status_in;
   logic                rsp_regv_ff, rsp_regv_in;
   logic [2:0]          rsp_idx_ff, rsp_idx_in;
   logic [15:0]         rsp_val_ff, rsp_val_in;
   logic                rsp_last_ff, rsp_last_in;

   crc_ctrl_type        crc_ctrl;
   logic                crc_busy;
   logic [15:0]         crc_val;
   store_ctrl_type      store_ctrl;
   logic [15:0]         rd_data;
   logic [1:0]          rd_present;

   logic                accept;
   logic [7:0]          pos_next, pos_m3;
   logic [6:0]          half_count;
   logic                slot_free;
   logic                is_regv;
   logic                is_last;
   logic                csr_write;

   mrc_crc_unit u_crc (
      .clock (clock),
      .reset (reset),
      .ctrl  (crc_ctrl),
      .busy  (crc_busy),
      .crc   (crc_val)
   );

   mrc_reg_store u_store (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (store_ctrl),
      .rd_data    (rd_data),
      .rd_present (rd_present)
   );

   assign req_tready = (state_ff == SEQ_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign pos_next   = (pos_ff == 8'hFF) ? 8'hFF : pos_ff + 8'd1;
   assign pos_m3     = pos_ff - 8'd3;
   assign half_count = count_byte_ff[7:1];
   assign slot_free  = !rsp_valid_ff || rsp_tready;
   assign is_regv    = (nreg_ff != '0);
   assign is_last    = !is_regv || (({1'b0, idx_ff} + 1'b1) == nreg_ff);

   always_comb begin
      state_in      = state_ff;
      pos_in        = pos_ff;
      delay0_in     = delay0_ff;
      delay1_in     = delay1_ff;
      addr_byte_in  = addr_byte_ff;
      func_in       = func_ff;
      count_byte_in = count_byte_ff;
      frame_len_in  = frame_len_ff;
      eof_in        = eof_ff;
      status_in     = status_ff;
      nreg_in       = nreg_ff;
      idx_in        = idx_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_regv_in   = rsp_regv_ff;
      rsp_idx_in    = rsp_idx_ff;
      rsp_val_in    = rsp_val_ff;
      rsp_last_in   = rsp_last_ff;

      crc_ctrl.init  = 1'b0;
      crc_ctrl.start = 1'b0;
      crc_ctrl.data  = delay0_ff;

      store_ctrl.wr_en   = 1'b0;
      store_ctrl.clear   = 1'b0;
      store_ctrl.wr_addr = pos_m3[ByteBits-1:0];
      store_ctrl.wr_data = req_tdata;
      store_ctrl.rd_row  = idx_ff;

      case (state_ff)
         SEQ_IDLE: begin
            if (accept) begin
               delay0_in = delay1_ff;
               delay1_in = req_tdata;
               eof_in    = req_tlast;
               if (pos_ff == 8'd0) begin
                  crc_ctrl.init    = 1'b1;
                  store_ctrl.clear = 1'b1;
                  addr_byte_in     = req_tdata;
               end else if (pos_ff == 8'd1) begin
                  func_in = req_tdata;
               end else if (pos_ff == 8'd2) begin
                  count_byte_in = req_tdata;
               end else if (pos_m3 < 8'(StoreBytes)) begin
                  store_ctrl.wr_en = 1'b1;
               end
               if (pos_ff >= 8'd2) begin
                  crc_ctrl.start = 1'b1;
               end
               if (req_tlast) begin
                  pos_in       = 8'd0;
                  frame_len_in = pos_next;
               end else begin
                  pos_in = pos_next;
               end
               if (pos_ff >= 8'd2) begin
                  state_in = SEQ_CRC;
               end else if (req_tlast) begin
                  state_in = SEQ_JUDGE;
               end
            end
         end
         SEQ_CRC: begin
            if (!crc_busy) begin
               state_in = eof_ff ? SEQ_JUDGE : SEQ_IDLE;
            end
         end
         SEQ_JUDGE: begin
            nreg_in = '0;
            idx_in  = '0;
            if (frame_len_ff < 8'd4 || delay0_ff != crc_val[7:0] ||
                delay1_ff != crc_val[15:8]) begin
               status_in = STAT_CRC_ERR;
            end else if (addr_byte_ff != exp_addr_ff) begin
               status_in = STAT_ADDR_ERR;
            end else begin
               case (func_ff)
                  FuncRead: begin
                     status_in = STAT_READ_OK;
                     if (half_count > 7'(MaxRegisters)) begin
                        nreg_in = (RowBits + 1)'(MaxRegisters);
                     end else begin
                        nreg_in = half_count[RowBits:0];
                     end
                  end
                  FuncWrite:    status_in = STAT_WRITE_OK;
                  FuncReadExc:  status_in = STAT_READ_EXC;
                  FuncWriteExc: status_in = STAT_WRITE_EXC;
                  default:      status_in = STAT_UNKNOWN;
               endcase
            end
            state_in = SEQ_FETCH;
         end
         SEQ_FETCH: begin
            state_in = SEQ_SEND;
         end
         SEQ_SEND: begin
            if (slot_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_regv_in   = is_regv;
               rsp_idx_in    = is_regv ? 3'(idx_ff) : 3'd0;
               rsp_val_in    = is_regv ? {rd_present[1] ? rd_data[15:8] : 8'd0,
                                          rd_present[0] ? rd_data[7:0]  : 8'd0} : 16'd0;
               rsp_last_in   = is_last;
               if (is_last) begin
                  state_in = SEQ_IDLE;
               end else begin
                  idx_in   = idx_ff + 1'b1;
                  state_in = SEQ_FETCH;
               end
            end
         end
         default: state_in = SEQ_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= SEQ_IDLE;
         pos_ff       <= 8'd0;
         delay0_ff    <= 8'd0;
         delay1_ff    <= 8'd0;
         eof_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         delay0_ff    <= delay0_in;
         delay1_ff    <= delay1_in;
         eof_ff       <= eof_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      addr_byte_ff  <= addr_byte_in;
      func_ff       <= func_in;
      count_byte_ff <= count_byte_in;
      frame_len_ff  <= frame_len_in;
      status_ff     <= status_in;
      nreg_ff       <= nreg_in;
      idx_ff        <= idx_in;
      rsp_status_ff <= rsp_status_in;
      rsp_regv_ff   <= rsp_regv_in;
      rsp_idx_ff    <= rsp_idx_in;
      rsp_val_ff    <= rsp_val_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign csr_write = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         exp_addr_ff <= 8'd1;
      end else if (csr_write && csr_paddr == CsrExpectedAddress) begin
         exp_addr_ff <= csr_pwdata[7:0];
      end
   end

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == CsrExpectedAddress) ? {24'd0, exp_addr_ff} : 32'd0;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_val_ff, rsp_idx_ff, rsp_status_ff};
   assign rsp_tuser  = rsp_regv_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

// ===== rtl/mrc_crc_unit.sv =====
module mrc_crc_unit (
   input  logic                  clock,
   input  logic                  reset,
   input  mrc_pkg::crc_ctrl_type ctrl,
   output logic                  busy,
   output logic [15:0]           crc
);
   import mrc_pkg::*;

   logic [15:0] crc_ff, crc_in;
   logic [7:0]  data_ff, data_in;
   logic [2:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic [15:0] crc_step;

   assign crc_step = (crc_ff[0] ^ data_ff[0]) ? ((crc_ff >> 1) ^ CrcPoly) : (crc_ff >> 1);

   always_comb begin
      crc_in  = crc_ff;
      data_in = data_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (ctrl.init) begin
         crc_in = CrcInit;
      end
      if (ctrl.start) begin
         busy_in = 1'b1;
         data_in = ctrl.data;
         cnt_in  = 3'd0;
      end else if (busy_ff) begin
         crc_in  = crc_step;
         data_in = data_ff >> 1;
         cnt_in  = cnt_ff + 3'd1;
         if (cnt_ff == 3'd7) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff  <= CrcInit;
         cnt_ff  <= 3'd0;
         busy_ff <= 1'b0;
      end else begin
         crc_ff  <= crc_in;
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
      end
      data_ff <= data_in;
   end

   assign busy = busy_ff;
   assign crc  = crc_ff;

endmodule

// ===== rtl/mrc_reg_store.sv =====
module mrc_reg_store (
   input  logic                    clock,
   input  logic                    reset,
   input  mrc_pkg::store_ctrl_type ctrl,
   output logic [15:0]             rd_data,
   output logic [1:0]              rd_present
);
   import mrc_pkg::*;

   logic [15:0]           mem [MaxRegisters];
   logic [StoreBytes-1:0] present_ff, present_in;
   logic [15:0]           rd_data_ff;
   logic [1:0]            rd_present_ff;
   logic [RowBits-1:0]    wr_row;

   assign wr_row = ctrl.wr_addr[ByteBits-1:1];

   always_comb begin
      present_in = present_ff;
      if (ctrl.clear) begin
         present_in = '0;
      end else if (ctrl.wr_en) begin
         present_in[ctrl.wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.wr_en) begin
         if (ctrl.wr_addr[0]) begin
            mem[wr_row][7:0] <= ctrl.wr_data;
         end else begin
            mem[wr_row][15:8] <= ctrl.wr_data;
         end
      end
      rd_data_ff <= mem[ctrl.rd_row];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         present_ff    <= '0;
         rd_present_ff <= 2'b00;
      end else begin
         present_ff    <= present_in;
         rd_present_ff <= {present_ff[{ctrl.rd_row, 1'b0}], present_ff[{ctrl.rd_row, 1'b1}]};
      end
   end

   assign rd_data    = rd_data_ff;
   assign rd_present = rd_present_ff;

endmodule

// ===== rtl/mrc_checker.sv =====
module mrc_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata,
   input logic        rsp_tuser,
   input logic        rsp_tlast
);

   a_hold_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result dropped while stalled");

   a_plain_single: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tlast && rsp_tdata[21:3] == 19'd0)
      else $error("non-register result not a lone cleared transaction");

   a_reg_status: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata[2:0] == 3'd0)
      else $error("register result with non-read status");

   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[2:0] != 3'd7 && rsp_tdata[23:22] == 2'b00)
      else $error("bad status code or padding");

   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result valid right after reset");

endmodule

bind modbus_reply_checker mrc_checker u_mrc_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

// ===== sim/modbus_reply_compare.sv =====
package reply_crc_pkg;

   function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ mrc_pkg::CrcPoly) : (c >> 1);
      end
      return c;
   endfunction

endpackage

module modbus_reply_compare (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   input  logic                            req_tready,
   input  logic [7:0]                      req_tdata,   // [7:0] rx_byte
   input  logic                            req_tlast,   // end_of_frame
   input  logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   input  logic [23:0]                     rsp_tdata,   // [2:0] status, [5:3] reg_index,
                                                        // [21:6] reg_value, [23:22] zero
   input  logic                            rsp_tuser,   // reg_valid
   input  logic                            rsp_tlast,   // last
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [mrc_pkg::CsrAddrBits-1:0] csr_paddr,
   input  logic [31:0]                     csr_pwdata,
   input  logic                            csr_pready,
   output int                              error_count,
   output int                              replies_waiting,
   output int                              replies_checked
);
   timeunit 1ns;
   timeprecision 1ps;

   import mrc_pkg::*;
   import reply_crc_pkg::*;

   typedef struct packed {
      status_type  status;
      logic        reg_valid;
      logic [2:0]  reg_index;
      logic [15:0] reg_value;
      logic        last;
   } reply_type;

   reply_type             predicted_replies[$];
   logic [7:0]            expected_addr;
   logic [15:0]           frame_crc;
   logic [7:0]            held_bytes [2];
   int                    frame_pos;
   logic [7:0]            addr_byte;
   logic [7:0]            func_byte;
   logic [7:0]            count_byte;
   logic [7:0]            data_bytes [StoreBytes];
   logic [StoreBytes-1:0] data_seen;
   int                    errors = 0;
   int                    checked = 0;

   function automatic void queue_reply(input status_type st, input logic valid,
                                       input logic [2:0] idx, input logic [15:0] val,
                                       input logic lst);
      reply_type r;
      r.status    = st;
      r.reg_valid = valid;
      r.reg_index = idx;
      r.reg_value = val;
      r.last      = lst;
      predicted_replies.push_back(r);
   endfunction

   function automatic void judge_frame();
      int         regs;
      int         i;
      logic [7:0] hi;
      logic [7:0] lo;
      if (frame_pos < 4 || held_bytes[0] != frame_crc[7:0] ||
          held_bytes[1] != frame_crc[15:8]) begin
         queue_reply(STAT_CRC_ERR, 1'b0, 3'd0, 16'h0000, 1'b1);
      end else if (addr_byte != expected_addr) begin
         queue_reply(STAT_ADDR_ERR, 1'b0, 3'd0, 16'h0000, 1'b1);
      end else begin
         case (func_byte)
            FuncRead: begin
               regs = count_byte / 2;
               if (regs > MaxRegisters) regs = MaxRegisters;
               if (regs == 0) queue_reply(STAT_READ_OK, 1'b0, 3'd0, 16'h0000, 1'b1);
               for (i = 0; i < regs; i++) begin
                  hi = data_seen[2*i] ? data_bytes[2*i] : 8'h00;
                  lo = data_seen[2*i+1] ? data_bytes[2*i+1] : 8'h00;
                  queue_reply(STAT_READ_OK, 1'b1, 3'(i), {hi, lo}, i == regs - 1);
               end
            end
            FuncWrite:    queue_reply(STAT_WRITE_OK, 1'b0, 3'd0, 16'h0000, 1'b1);
            FuncReadExc:  queue_reply(STAT_READ_EXC, 1'b0, 3'd0, 16'h0000, 1'b1);
            FuncWriteExc: queue_reply(STAT_WRITE_EXC, 1'b0, 3'd0, 16'h0000, 1'b1);
            default:      queue_reply(STAT_UNKNOWN, 1'b0, 3'd0, 16'h0000, 1'b1);
         endcase
      end
   endfunction

   function automatic void take_byte(input logic [7:0] b, input logic eof);
      if (frame_pos == 0) begin
         frame_crc = CrcInit;
         data_seen = '0;
      end
      if (frame_pos >= 2) frame_crc = crc16_byte(frame_crc, held_bytes[0]);
      held_bytes[0] = held_bytes[1];
      held_bytes[1] = b;
      if (frame_pos == 0) begin
         addr_byte = b;
      end else if (frame_pos == 1) begin
         func_byte = b;
      end else if (frame_pos == 2) begin
         count_byte = b;
      end else if (frame_pos - 3 < StoreBytes) begin
         data_bytes[frame_pos-3] = b;
         data_seen[frame_pos-3]  = 1'b1;
      end
      if (frame_pos < 255) frame_pos++;
      if (eof) begin
         judge_frame();
         frame_pos = 0;
      end
   endfunction

   always @(posedge clock) begin
      reply_type want;
      if (reset) begin
         predicted_replies.delete();
         expected_addr = 8'd1;
         frame_crc     = CrcInit;
         held_bytes[0] = 8'h00;
         held_bytes[1] = 8'h00;
         frame_pos     = 0;
         addr_byte     = 8'h00;
         func_byte     = 8'h00;
         count_byte    = 8'h00;
         data_seen     = '0;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
             csr_paddr == CsrExpectedAddress) begin
            expected_addr = csr_pwdata[7:0];
         end
         if (req_tvalid && req_tready) take_byte(req_tdata, req_tlast);
         if (rsp_tvalid && rsp_tready) begin
            if (predicted_replies.size() == 0) begin
               errors++;
               $display("%0t: unexpected result, expected none, actual tdata %h tuser %b tlast %b",
                        $time, rsp_tdata, rsp_tuser, rsp_tlast);
            end else begin
               want = predicted_replies.pop_front();
               checked++;
               if (rsp_tdata[2:0] != want.status || rsp_tdata[5:3] != want.reg_index ||
                   rsp_tdata[21:6] != want.reg_value || rsp_tdata[23:22] != 2'b00 ||
                   rsp_tuser != want.reg_valid || rsp_tlast != want.last) begin
                  errors++;
                  $display({"%0t: result mismatch, expected status %0d valid %b index %0d ",
                            "value %h last %b, actual status %0d valid %b index %0d value %h ",
                            "last %b pad %b"},
                           $time, want.status, want.reg_valid, want.reg_index,
                           want.reg_value, want.last, rsp_tdata[2:0], rsp_tuser,
                           rsp_tdata[5:3], rsp_tdata[21:6], rsp_tlast, rsp_tdata[23:22]);
               end
            end
         end
      end
      error_count     <= errors;
      replies_waiting <= predicted_replies.size();
      replies_checked <= checked;
   end

endmodule

// ===== sim/modbus_reply_checker_tb.sv =====
module modbus_reply_checker_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import mrc_pkg::*;
   import reply_crc_pkg::*;

   localparam int CycleLimit   = 400000;
   localparam int SettleCycles = 40;
   localparam int IdlePercent  = 12;

   logic                   clock       = 1'b0;
   logic                   reset       = 1'b1;
   logic                   req_tvalid  = 1'b0;
   logic                   req_tready;
   logic [7:0]             req_tdata   = 8'h00;
   logic                   req_tlast   = 1'b0;
   logic                   rsp_tvalid;
   logic                   rsp_tready  = 1'b0;
   logic [23:0]            rsp_tdata;
   logic                   rsp_tuser;
   logic                   rsp_tlast;
   logic                   csr_psel    = 1'b0;
   logic                   csr_penable = 1'b0;
   logic                   csr_pwrite  = 1'b0;
   logic [CsrAddrBits-1:0] csr_paddr   = '0;
   logic [31:0]            csr_pwdata  = 32'h0;
   logic [31:0]            csr_prdata;
   logic                   csr_pready;

   int         error_count;
   int         replies_waiting;
   int         replies_checked;
   logic [7:0] frame_buf[$];
   logic [7:0] slave_addr   = 8'd1;
   bit         steady       = 1'b0;
   int         bytes_sent   = 0;
   int         frames_sent  = 0;
   int         settings_used = 0;
   int         cycle_count  = 0;

   always #10 clock = ~clock;

   modbus_reply_checker u_top (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   modbus_reply_compare u_check (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .req_tlast       (req_tlast),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .rsp_tuser       (rsp_tuser),
      .rsp_tlast       (rsp_tlast),
      .csr_psel        (csr_psel),
      .csr_penable     (csr_penable),
      .csr_pwrite      (csr_pwrite),
      .csr_paddr       (csr_paddr),
      .csr_pwdata      (csr_pwdata),
      .csr_pready      (csr_pready),
      .error_count     (error_count),
      .replies_waiting (replies_waiting),
      .replies_checked (replies_checked)
   );

   always @(posedge clock) begin
      rsp_tready <= steady || ($urandom_range(99) >= IdlePercent);
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("timeout after %0d cycles, %0d results outstanding", CycleLimit,
                  replies_waiting);
         $display("DONE: errors detected");
         $finish;
      end
   end

   function automatic void push_random(input int n);
      repeat (n) frame_buf.push_back(8'($urandom));
   endfunction

   function automatic void start_frame(input logic [7:0] addr, input logic [7:0] func);
      frame_buf.delete();
      frame_buf.push_back(addr);
      frame_buf.push_back(func);
   endfunction

   function automatic void build_read(input logic [7:0] addr, input logic [7:0] count,
                                      input int data_len);
      start_frame(addr, FuncRead);
      frame_buf.push_back(count);
      push_random(data_len);
   endfunction

   function automatic void append_crc(input bit corrupt);
      logic [15:0] crc;
      crc = CrcInit;
      foreach (frame_buf[i]) crc = crc16_byte(crc, frame_buf[i]);
      if (corrupt) crc ^= 16'(1 << $urandom_range(15));
      frame_buf.push_back(crc[7:0]);
      frame_buf.push_back(crc[15:8]);
   endfunction

   task automatic send_byte(input logic [7:0] b, input logic eof);
      while (!steady && $urandom_range(99) < IdlePercent) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= eof;
      do @(posedge clock); while (!req_tready);
      bytes_sent++;
   endtask

   task automatic send_frame();
      foreach (frame_buf[i]) send_byte(frame_buf[i], i == frame_buf.size() - 1);
      frames_sent++;
   endtask

   // hold the sender until every predicted result has been taken
   task automatic drain(input int settle);
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (replies_waiting != 0) @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   task automatic write_expected_addr(input logic [7:0] a);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CsrExpectedAddress;
      csr_pwdata  <= {24'h0, a};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      slave_addr = a;
      settings_used++;
   endtask

   task automatic random_frame();
      int         kind;
      int         count;
      int         data_len;
      logic [7:0] addr;
      kind = $urandom_range(99);
      addr = ($urandom_range(9) < 8) ? slave_addr : 8'($urandom);
      if (kind < 45) begin
         case ($urandom_range(3))
            0, 1:    count = 2 * $urandom_range(MaxRegisters);
            2:       count = $urandom_range(255);
            default: count = 2 * $urandom_range(MaxRegisters) + 1;
         endcase
         data_len = (count > 20) ? $urandom_range(20) : count;
         if ($urandom_range(9) == 0) data_len = $urandom_range(20);
         build_read(addr, 8'(count), data_len);
      end else if (kind < 85) begin
         case ($urandom_range(4))
            0, 1: begin
               start_frame(addr, FuncWrite);
               push_random(4);
            end
            2: begin
               start_frame(addr, FuncReadExc);
               push_random(1);
            end
            3: begin
               start_frame(addr, FuncWriteExc);
               push_random(1);
            end
            default: begin
               start_frame(addr, 8'($urandom));
               push_random($urandom_range(4));
            end
         endcase
      end else begin
         frame_buf.delete();
         push_random($urandom_range(1, 8));
      end
      if (kind < 85) begin
         append_crc($urandom_range(99) < 8);
         if ($urandom_range(99) < 4)
            frame_buf[$urandom_range(frame_buf.size() - 1)] ^= 8'(1 << $urandom_range(7));
      end
      send_frame();
   endtask

   initial begin
      int base;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      start_frame(8'd1, FuncWrite);
      frame_buf.push_back(8'h00);
      frame_buf.push_back(8'h10);
      frame_buf.push_back(8'hFF);
      frame_buf.push_back(8'hFF);
      append_crc(1'b0);
      send_frame();

      // frames too short to carry a CRC
      frame_buf.delete();
      frame_buf.push_back(8'h01);
      send_frame();
      frame_buf.push_back(FuncRead);
      send_frame();
      frame_buf.push_back(8'h00);
      send_frame();

      start_frame(8'd1, FuncRead);
      append_crc(1'b0);
      send_frame();
      start_frame(8'd1, FuncReadExc);
      frame_buf.push_back(8'h02);
      append_crc(1'b0);
      send_frame();
      start_frame(8'd1, FuncWriteExc);
      frame_buf.push_back(8'h04);
      append_crc(1'b0);
      send_frame();
      start_frame(8'd1, 8'h2B);
      frame_buf.push_back(8'h00);
      append_crc(1'b0);
      send_frame();
      start_frame(8'd2, FuncWrite);
      push_random(4);
      append_crc(1'b0);
      send_frame();

      start_frame(8'd1, FuncRead);
      frame_buf.push_back(8'd16);
      for (int i = 0; i < 16; i++)
         frame_buf.push_back(i < 2 ? 8'h00 : (i < 4 ? 8'hFF : 8'($urandom)));
      append_crc(1'b0);
      send_frame();
      build_read(8'd1, 8'd0, 0);
      append_crc(1'b0);
      send_frame();
      build_read(8'd1, 8'd1, 1);
      append_crc(1'b0);
      send_frame();
      build_read(8'd1, 8'd255, 20);
      append_crc(1'b0);
      send_frame();
      build_read(8'd1, 8'd12, 3);
      append_crc(1'b0);
      send_frame();
      build_read(8'd1, 8'd4, 4);
      append_crc(1'b1);
      send_frame();
      // position counter saturates past 255 bytes
      build_read(8'd1, 8'd255, 253);
      append_crc(1'b0);
      send_frame();
      drain(SettleCycles);

      write_expected_addr(8'd0);
      start_frame(8'd0, FuncWrite);
      push_random(4);
      append_crc(1'b0);
      send_frame();
      build_read(8'd1, 8'd2, 2);
      append_crc(1'b0);
      send_frame();
      drain(SettleCycles);

      write_expected_addr(8'd255);
      build_read(8'd255, 8'd4, 4);
      append_crc(1'b0);
      send_frame();
      start_frame(8'd0, FuncWrite);
      push_random(4);
      append_crc(1'b0);
      send_frame();
      drain(SettleCycles);

      base = bytes_sent;
      for (int phase = 0; phase < 4; phase++) begin
         write_expected_addr(8'($urandom));
         steady = (phase == 2);
         while (bytes_sent - base < 20 * (phase + 1)) begin
            random_frame();
            if ($urandom_range(99) < 5) drain(0);
         end
         drain(SettleCycles);
      end

      $display("covered %0d frames, %0d bytes, %0d slave address settings, %0d results checked",
               frames_sent, bytes_sent, settings_used, replies_checked);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

// ===== modbus_reply_checker.f =====
rtl/mrc_pkg.sv
rtl/mrc_crc_unit.sv
rtl/mrc_reg_store.sv
rtl/modbus_reply_checker.sv
rtl/mrc_checker.sv
sim/modbus_reply_compare.sv
sim/modbus_reply_checker_tb.sv
